@@ rtl/sfp_pkg.sv @@
// Shared types, character codes and CRC function for the serial command frame parser.
`timescale 1ns / 1ps
package sfp_pkg;

  // Framing characters
  localparam logic [7:0] CH_M  = 8'h4D;  // 'M', v1 start
  localparam logic [7:0] CH_X  = 8'h58;  // 'X', v2 native start
  localparam logic [7:0] CH_LT = 8'h3C;  // '<', command
  localparam logic [7:0] CH_GT = 8'h3E;  // '>', reply

  localparam logic [7:0] CMD_TUNNEL   = 8'hFF;  // v1 cmd that carries a v2 header
  localparam logic [7:0] TUN_MIN_SIZE = 8'd6;   // v2 header + crc inside v1 payload
  localparam logic [7:0] CRC_POLY     = 8'hD5;  // CRC-8 DVB-S2

  localparam int unsigned HDR_DEPTH = 7;

  // Frame version codes
  localparam logic [1:0] VER_V1  = 2'd0;
  localparam logic [1:0] VER_TUN = 2'd1;
  localparam logic [1:0] VER_NAT = 2'd2;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_GOT_M    = 4'd1,
    PH_GOT_X    = 4'd2,
    PH_V1_HDR   = 4'd3,
    PH_V1_DATA  = 4'd4,
    PH_V1_CHK   = 4'd5,
    PH_TUN_HDR  = 4'd6,
    PH_TUN_DATA = 4'd7,
    PH_TUN_CRC  = 4'd8,
    PH_NAT_HDR  = 4'd9,
    PH_NAT_DATA = 4'd10,
    PH_NAT_CRC  = 4'd11
  } phase_t;

  // One result item
  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic        frame_done;
    logic        frame_dropped;
    logic        is_reply;
    logic [1:0]  frame_version;
    logic [15:0] command_id;
    logic [7:0]  command_flags;
    logic [8:0]  payload_length;
  } result_t;

  // One byte through CRC-8, MSB first
  function automatic logic [7:0] crc8_d5(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] r;
    r = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    end
    return r;
  endfunction

endpackage

@@ rtl/sfp_byte_if.sv @@
// Received byte channel: valid/ready handshake with one serial byte.
`timescale 1ns / 1ps
interface sfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ rtl/sfp_result_if.sv @@
// Result channel: valid/ready handshake with one parser result per byte.
`timescale 1ns / 1ps
interface sfp_result_if;
  logic        valid;
  logic        ready;
  logic        payload_valid;
  logic [7:0]  payload_byte;
  logic [7:0]  payload_index;
  logic        frame_done;
  logic        frame_dropped;
  logic        is_reply;
  logic [1:0]  frame_version;
  logic [15:0] command_id;
  logic [7:0]  command_flags;
  logic [8:0]  payload_length;

  modport source (
    output valid, output payload_valid, output payload_byte, output payload_index,
    output frame_done, output frame_dropped, output is_reply, output frame_version,
    output command_id, output command_flags, output payload_length,
    input ready
  );
  modport sink (
    input valid, input payload_valid, input payload_byte, input payload_index,
    input frame_done, input frame_dropped, input is_reply, input frame_version,
    input command_id, input command_flags, input payload_length,
    output ready
  );
endinterface

@@ rtl/serial_command_frame_parser.sv @@
// Top level of the serial command frame parser: v1, tunnelled v2 and native v2 frames.
//
//   channel   dir  handshake      payload
//   rx_chan   in   valid / ready  rx_byte (8)
//   res_chan  out  valid / ready  payload_valid, payload_byte, payload_index,
//                                 frame_done, frame_dropped, is_reply, frame_version,
//                                 command_id, command_flags, payload_length
//
// Flow: every byte gives exactly one result transfer. A byte passes through the
//   input register, then the parse logic into the result register; with ready held
//   high one byte is taken and one result delivered every cycle.
// Reset: synchronous, active high; parser returns to hunting for a start byte and
//   both pipeline stages are emptied. The header byte store is not cleared.
// Stalls: when res_chan.ready is low and the result register is full, the parser
//   holds its state and rx_chan.ready drops once the input register is also full.
`timescale 1ns / 1ps
module serial_command_frame_parser import sfp_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = 256
) (
  input  logic         clk,
  input  logic         rst,
  sfp_byte_if.sink     rx_chan,
  sfp_result_if.source res_chan
);

  logic       can_load;  // result register can take a new result this cycle
  logic       step;      // input register byte moves through the parser
  logic [7:0] byte_q;
  result_t    res;

  // Stage 1: capture the received byte
  sfp_in_reg u_in (
    .clk      (clk),
    .rst      (rst),
    .rx_chan  (rx_chan),
    .can_load (can_load),
    .step     (step),
    .byte_q   (byte_q)
  );

  // Parse state machine: one byte per step, payload streamed out with its index,
  // XOR checksum for v1 and CRC-8 (0xD5) for v2, both checked on tunnelled frames
  sfp_parse_core #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .byte_in (byte_q),
    .res     (res)
  );

  // Stage 2: result register decouples the sink's ready from the parser
  sfp_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (step),
    .res_in   (res),
    .can_load (can_load),
    .res_chan (res_chan)
  );

endmodule

@@ rtl/sfp_in_reg.sv @@
// Input register stage: captures one received byte and hands it to the parser.
`timescale 1ns / 1ps
module sfp_in_reg (
  input  logic       clk,
  input  logic       rst,
  sfp_byte_if.sink   rx_chan,
  input  logic       can_load,
  output logic       step,
  output logic [7:0] byte_q
);

  logic vld;

  assign step          = vld && can_load;
  assign rx_chan.ready = !vld || can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (rx_chan.ready) begin
      vld <= rx_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_chan.valid && rx_chan.ready) begin
      byte_q <= rx_chan.rx_byte;
    end
  end

endmodule

@@ rtl/sfp_parse_core.sv @@
// Frame parser state, header store, XOR and CRC-8 checksums, per-byte result logic.
`timescale 1ns / 1ps
module sfp_parse_core import sfp_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] byte_in,
  output result_t    res
);

  localparam int unsigned LEN_W = $clog2(MAX_PAYLOAD + 1);
  localparam logic [15:0] MAX_LEN = 16'(MAX_PAYLOAD);

  phase_t             phase, phase_next;
  logic [1:0]         version, version_next;
  logic               reply, reply_next;
  logic [LEN_W-1:0]   offset, offset_next;
  logic [7:0]         xor_sum, xor_sum_next;
  logic [7:0]         crc_sum, crc_sum_next;
  logic [LEN_W-1:0]   length, length_next;
  logic [15:0]        command, command_next;
  logic [7:0]         flags, flags_next;
  logic [7:0]         hdr [HDR_DEPTH];

  logic               hdr_we;
  logic [LEN_W-1:0]   offset_inc;
  logic [7:0]         crc_upd;
  logic [15:0]        v1_size;
  logic [15:0]        v2_size;
  logic [15:0]        v2_cmd;
  logic [7:0]         v2_flags;
  logic               pv, done, drop, framed;
  logic [15:0]        offset16, length16;

  assign offset_inc = offset + LEN_W'(1);
  assign crc_upd    = crc8_d5(crc_sum, byte_in);
  assign v1_size    = {8'h00, hdr[0]};
  assign offset16   = 16'(offset);

  // v2 header fields; the last size byte is the current byte
  always_comb begin
    if (phase == PH_TUN_HDR) begin
      v2_flags = hdr[2];
      v2_cmd   = {hdr[4], hdr[3]};
      v2_size  = {byte_in, hdr[5]};
    end else begin
      v2_flags = hdr[0];
      v2_cmd   = {hdr[2], hdr[1]};
      v2_size  = {byte_in, hdr[3]};
    end
  end

  always_comb begin
    phase_next   = phase;
    version_next = version;
    reply_next   = reply;
    offset_next  = offset;
    xor_sum_next = xor_sum;
    crc_sum_next = crc_sum;
    length_next  = length;
    command_next = command;
    flags_next   = flags;
    hdr_we       = 1'b0;
    pv           = 1'b0;
    done         = 1'b0;
    drop         = 1'b0;

    unique case (phase)
      PH_GOT_M, PH_GOT_X: begin
        if (byte_in == CH_LT || byte_in == CH_GT) begin
          reply_next = (byte_in == CH_GT);
          phase_next = (phase == PH_GOT_M) ? PH_V1_HDR : PH_NAT_HDR;
        end else begin
          drop = 1'b1;
        end
      end
      PH_V1_HDR: begin
        hdr_we       = 1'b1;
        offset_next  = offset_inc;
        xor_sum_next = xor_sum ^ byte_in;
        if (offset == LEN_W'(1)) begin
          if (v1_size > MAX_LEN) begin
            drop = 1'b1;
          end else if (byte_in == CMD_TUNNEL) begin
            if (hdr[0] >= TUN_MIN_SIZE) begin
              version_next = VER_TUN;
              phase_next   = PH_TUN_HDR;
            end else begin
              drop = 1'b1;
            end
          end else begin
            length_next  = LEN_W'(v1_size);
            command_next = {8'h00, byte_in};
            flags_next   = 8'h00;
            offset_next  = '0;
            phase_next   = (hdr[0] != 8'h00) ? PH_V1_DATA : PH_V1_CHK;
          end
        end
      end
      PH_V1_DATA, PH_TUN_DATA, PH_NAT_DATA: begin
        pv          = 1'b1;
        offset_next = offset_inc;
        if (phase != PH_NAT_DATA) begin
          xor_sum_next = xor_sum ^ byte_in;
        end
        if (phase != PH_V1_DATA) begin
          crc_sum_next = crc_upd;
        end
        if (offset_inc >= length) begin
          phase_next = (phase == PH_V1_DATA)  ? PH_V1_CHK :
                       (phase == PH_TUN_DATA) ? PH_TUN_CRC : PH_NAT_CRC;
        end
      end
      PH_V1_CHK, PH_NAT_CRC: begin
        if ((phase == PH_V1_CHK ? xor_sum : crc_sum) == byte_in) begin
          done = 1'b1;
        end else begin
          drop = 1'b1;
        end
        phase_next = PH_IDLE;
      end
      PH_TUN_HDR, PH_NAT_HDR: begin
        hdr_we       = (offset < LEN_W'(HDR_DEPTH));
        offset_next  = offset_inc;
        crc_sum_next = crc_upd;
        if (phase == PH_TUN_HDR) begin
          xor_sum_next = xor_sum ^ byte_in;
        end
        if ((phase == PH_TUN_HDR && offset == LEN_W'(6)) ||
            (phase == PH_NAT_HDR && offset == LEN_W'(4))) begin
          if (v2_size > MAX_LEN) begin
            drop = 1'b1;
          end else begin
            flags_next   = v2_flags;
            command_next = v2_cmd;
            length_next  = LEN_W'(v2_size);
            offset_next  = '0;
            if (phase == PH_TUN_HDR) begin
              phase_next = (v2_size != 16'h0000) ? PH_TUN_DATA : PH_TUN_CRC;
            end else begin
              phase_next = (v2_size != 16'h0000) ? PH_NAT_DATA : PH_NAT_CRC;
            end
          end
        end
      end
      PH_TUN_CRC: begin
        xor_sum_next = xor_sum ^ byte_in;
        if (crc_sum == byte_in) begin
          phase_next = PH_V1_CHK;
        end else begin
          drop = 1'b1;
        end
      end
      default: begin
        // idle, and any code without meaning: hunt for a start byte
        offset_next  = '0;
        xor_sum_next = 8'h00;
        crc_sum_next = 8'h00;
        reply_next   = 1'b0;
        if (byte_in == CH_M) begin
          phase_next   = PH_GOT_M;
          version_next = VER_V1;
        end else if (byte_in == CH_X) begin
          phase_next   = PH_GOT_X;
          version_next = VER_NAT;
        end else begin
          phase_next = PH_IDLE;
        end
      end
    endcase

    if (drop) begin
      phase_next = PH_IDLE;
    end
  end

  assign framed   = pv || done || drop;
  assign length16 = 16'(length_next);

  always_comb begin
    res                = '0;
    res.payload_valid  = pv;
    res.payload_byte   = pv ? byte_in : 8'h00;
    res.payload_index  = pv ? offset16[7:0] : 8'h00;
    res.frame_done     = done;
    res.frame_dropped  = drop;
    res.is_reply       = framed ? reply_next : 1'b0;
    res.frame_version  = framed ? version_next : 2'b00;
    res.command_id     = done ? command_next : 16'h0000;
    res.command_flags  = done ? flags_next : 8'h00;
    res.payload_length = done ? length16[8:0] : 9'h000;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_IDLE;
      version <= VER_V1;
      reply   <= 1'b0;
      offset  <= '0;
      xor_sum <= 8'h00;
      crc_sum <= 8'h00;
      length  <= '0;
      command <= 16'h0000;
      flags   <= 8'h00;
    end else if (step) begin
      phase   <= phase_next;
      version <= version_next;
      reply   <= reply_next;
      offset  <= offset_next;
      xor_sum <= xor_sum_next;
      crc_sum <= crc_sum_next;
      length  <= length_next;
      command <= command_next;
      flags   <= flags_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && hdr_we) begin
      hdr[offset[2:0]] <= byte_in;
    end
  end

  // A frame that ends or drops always returns to hunting
  a_end_to_idle: assert property (@(posedge clk) disable iff (rst)
    step && (done || drop) |=> phase == PH_IDLE)
    else $error("parser did not return to idle after frame end");

  // Payload index stays inside the declared length
  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    step && pv |-> offset < length)
    else $error("payload byte beyond frame length");

  // Data phases only run with a nonzero length within the limit
  a_data_len: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_V1_DATA || phase == PH_TUN_DATA || phase == PH_NAT_DATA) |->
      (length != '0) && (16'(length) <= MAX_LEN))
    else $error("data phase with bad length");

endmodule

@@ rtl/sfp_out_reg.sv @@
// Result register: holds one parser result until the sink takes it.
`timescale 1ns / 1ps
module sfp_out_reg import sfp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  result_t     res_in,
  output logic        can_load,
  sfp_result_if.source res_chan
);

  logic    vld;
  result_t data;

  assign can_load = !vld || res_chan.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (can_load) begin
      vld <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= res_in;
    end
  end

  assign res_chan.valid          = vld;
  assign res_chan.payload_valid  = data.payload_valid;
  assign res_chan.payload_byte   = data.payload_byte;
  assign res_chan.payload_index  = data.payload_index;
  assign res_chan.frame_done     = data.frame_done;
  assign res_chan.frame_dropped  = data.frame_dropped;
  assign res_chan.is_reply       = data.is_reply;
  assign res_chan.frame_version  = data.frame_version;
  assign res_chan.command_id     = data.command_id;
  assign res_chan.command_flags  = data.command_flags;
  assign res_chan.payload_length = data.payload_length;

endmodule
